/* hw/rtl/rcsp_pkg.sv */
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared types, codes and defaults for the reference-counted slot pool.
// ----------------------------------------------------------------------------
package rcsp_pkg;

  localparam int SLOTS_DEF        = 8;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int MSG_LEN_RESET    = 64;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 3;
  localparam int SLOT_BIT_W = $clog2(SLOT_W);
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 14;
  localparam int CNT_W    = 5;
  localparam int FREE_W   = 4;
  localparam int SUB_W    = 4;
  localparam int MSG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOCATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOCATE   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSCRIBERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LENGTH  = 1'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic                for_transmit;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [ADDR_W-1:0]   frame_address;
    logic [ADDR_W-1:0]   payload_address;
    logic [CNT_W-1:0]    pending_reads;
    logic [FREE_W-1:0]   free_slots;
  } rsp_t;

  // update of one slot's stored count
  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] count;
    logic             set_busy;
    logic             clr_busy;
  } store_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ADDR,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/rcsp_alu.sv */
// ----------------------------------------------------------------------------
// rcsp_alu
// Shared address adder: optionally doubles the accumulator, then adds.
// ----------------------------------------------------------------------------
module rcsp_alu (
  input  logic                      dbl,
  input  logic [rcsp_pkg::ADDR_W-1:0] a,
  input  logic [rcsp_pkg::ADDR_W-1:0] b,
  output logic [rcsp_pkg::ADDR_W-1:0] sum
);

  logic [rcsp_pkg::ADDR_W-1:0] a_eff;

  always_comb begin
    a_eff = dbl ? {a[rcsp_pkg::ADDR_W-2:0], 1'b0} : a;
    sum   = a_eff + b;
  end

endmodule

/* hw/rtl/rcsp_store.sv */
// ----------------------------------------------------------------------------
// rcsp_store
// Pending-read counts in a memory, per-slot busy flags and the free counter.
// ----------------------------------------------------------------------------
module rcsp_store #(
  parameter int SLOTS = rcsp_pkg::SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CNTF_W = $clog2(SLOTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [IDX_W-1:0]             rd_idx,
  output logic [rcsp_pkg::CNT_W-1:0]   rd_data,
  input  logic [IDX_W-1:0]             idx,
  output logic                         busy_bit,
  input  rcsp_pkg::store_cmd_t         cmd,
  output logic [CNTF_W-1:0]            free_next
);

  logic [rcsp_pkg::CNT_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]           busy_q;
  logic [CNTF_W-1:0]          free_cnt;

  // entries are only trusted while their busy flag is set
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[idx] <= cmd.count;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q   <= '0;
      free_cnt <= CNTF_W'(SLOTS);
    end else begin
      if (cmd.set_busy) begin
        busy_q[idx] <= 1'b1;
      end else if (cmd.clr_busy) begin
        busy_q[idx] <= 1'b0;
      end
      free_cnt <= free_next;
    end
  end

  always_comb begin
    busy_bit  = busy_q[idx];
    free_next = free_cnt - CNTF_W'(cmd.set_busy) + CNTF_W'(cmd.clr_busy);
  end

endmodule

/* hw/rtl/rcsp_ctrl.sv */
// ----------------------------------------------------------------------------
// rcsp_ctrl
// Request sequencer: slot scan, shift-add address build and result register.
// ----------------------------------------------------------------------------
module rcsp_ctrl #(
  parameter int SLOTS        = rcsp_pkg::SLOTS_DEF,
  parameter int HEADER_BYTES = rcsp_pkg::HEADER_BYTES_DEF,
  parameter int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CNTF_W       = $clog2(SLOTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rcsp_pkg::req_t               req,
  input  logic [rcsp_pkg::SUB_W-1:0]   sub_count,
  input  logic [rcsp_pkg::ADDR_W-1:0]  stride,
  output logic                         done,
  output rcsp_pkg::rsp_t               rsp,
  // store side
  output logic                         rd_en,
  output logic [IDX_W-1:0]             rd_idx,
  input  logic [rcsp_pkg::CNT_W-1:0]   rd_data,
  output logic [IDX_W-1:0]             idx_out,
  input  logic                         busy_bit,
  output rcsp_pkg::store_cmd_t         cmd,
  input  logic [CNTF_W-1:0]            free_next,
  // shared adder
  output logic                         alu_dbl,
  output logic [rcsp_pkg::ADDR_W-1:0]  alu_a,
  output logic [rcsp_pkg::ADDR_W-1:0]  alu_b,
  input  logic [rcsp_pkg::ADDR_W-1:0]  alu_sum
);

  rcsp_pkg::state_t state, state_next;

  logic [rcsp_pkg::ACTION_W-1:0]   act;
  logic [rcsp_pkg::SLOT_W-1:0]     slot;
  logic                            tx;
  logic                            in_range;
  logic [IDX_W-1:0]                idx;
  logic [rcsp_pkg::SLOT_BIT_W-1:0] bitk;
  logic [rcsp_pkg::ADDR_W-1:0]     acc;
  logic [rcsp_pkg::ADDR_W-1:0]     payload;
  rcsp_pkg::rsp_t                  rsp_q;
  rcsp_pkg::rsp_t                  rsp_next;
  logic                            done_q;

  logic [IDX_W+rcsp_pkg::SLOT_W-1:0]  req_slot_ext;
  logic [IDX_W+rcsp_pkg::SLOT_W-1:0]  idx_ext;
  logic [CNTF_W+rcsp_pkg::FREE_W-1:0] free_ext;
  logic [rcsp_pkg::CNT_W-1:0]         cnt_new;
  logic                               req_in_range;

  always_comb begin
    req_slot_ext = {{IDX_W{1'b0}}, req.slot};
    req_in_range = req_slot_ext < (IDX_W + rcsp_pkg::SLOT_W)'(SLOTS);
    idx_ext      = {{rcsp_pkg::SLOT_W{1'b0}}, idx};
    free_ext     = {{rcsp_pkg::FREE_W{1'b0}}, free_next};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rcsp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (req.action == rcsp_pkg::ACT_ALLOCATE) ? rcsp_pkg::ST_SCAN
                                                                : rcsp_pkg::ST_MUL;
        end
      end
      rcsp_pkg::ST_SCAN: begin
        if (!busy_bit) begin
          state_next = rcsp_pkg::ST_ADDR;
        end else if (idx == IDX_W'(SLOTS - 1)) begin
          state_next = rcsp_pkg::ST_FINISH;
        end
      end
      rcsp_pkg::ST_MUL: begin
        if (bitk == '0) begin
          state_next = rcsp_pkg::ST_ADDR;
        end
      end
      rcsp_pkg::ST_ADDR:   state_next = rcsp_pkg::ST_FINISH;
      rcsp_pkg::ST_FINISH: state_next = rcsp_pkg::ST_IDLE;
      default:             state_next = rcsp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    busy     = (state != rcsp_pkg::ST_IDLE);
    rd_en    = (state == rcsp_pkg::ST_IDLE) && start;
    rd_idx   = req_slot_ext[IDX_W-1:0];
    idx_out  = idx;
    alu_dbl  = 1'b0;
    alu_a    = acc;
    alu_b    = '0;
    cmd      = '0;
    cnt_new  = '0;
    rsp_next = '0;
    rsp_next.slot_index      = slot;
    rsp_next.frame_address   = acc;
    rsp_next.payload_address = payload;

    case (state)
      rcsp_pkg::ST_SCAN: begin
        alu_b = stride;
      end
      rcsp_pkg::ST_MUL: begin
        // msb-first shift-add of the slot number times the stride
        alu_dbl = 1'b1;
        alu_b   = slot[bitk] ? stride : '0;
      end
      rcsp_pkg::ST_ADDR: begin
        alu_b = rcsp_pkg::ADDR_W'(HEADER_BYTES);
      end
      rcsp_pkg::ST_FINISH: begin
        case (act)
          rcsp_pkg::ACT_ALLOCATE: begin
            if (busy_bit) begin
              // pool full: index and addresses report zero
              rsp_next.status          = rcsp_pkg::STAT_NO_FREE;
              rsp_next.slot_index      = '0;
              rsp_next.frame_address   = '0;
              rsp_next.payload_address = '0;
            end else begin
              cnt_new = rcsp_pkg::CNT_W'(sub_count) + rcsp_pkg::CNT_W'(tx);
              cmd.we       = 1'b1;
              cmd.count    = cnt_new;
              cmd.set_busy = (cnt_new != '0);
              rsp_next.status        = rcsp_pkg::STAT_OK;
              rsp_next.slot_index    = idx_ext[rcsp_pkg::SLOT_W-1:0];
              rsp_next.pending_reads = cnt_new;
            end
          end
          rcsp_pkg::ACT_RELEASE: begin
            if (!in_range || !busy_bit) begin
              rsp_next.status = rcsp_pkg::STAT_ALREADY_FREE;
            end else begin
              cnt_new = rd_data - rcsp_pkg::CNT_W'(1);
              cmd.we       = 1'b1;
              cmd.count    = cnt_new;
              cmd.clr_busy = (cnt_new == '0);
              rsp_next.status        = rcsp_pkg::STAT_OK;
              rsp_next.pending_reads = cnt_new;
            end
          end
          default: begin
            // locate, also for the unused action code
            rsp_next.status        = rcsp_pkg::STAT_OK;
            rsp_next.pending_reads = (in_range && busy_bit) ? rd_data : '0;
          end
        endcase
        rsp_next.free_slots = free_ext[rcsp_pkg::FREE_W-1:0];
      end
      default: begin
      end
    endcase

    done = done_q;
    rsp  = rsp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rcsp_pkg::ST_IDLE;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= (state == rcsp_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rcsp_pkg::ST_IDLE: begin
        if (start) begin
          act      <= req.action;
          slot     <= req.slot;
          tx       <= req.for_transmit;
          in_range <= req_in_range;
          acc      <= '0;
          bitk     <= rcsp_pkg::SLOT_BIT_W'(rcsp_pkg::SLOT_W - 1);
          idx      <= (req.action == rcsp_pkg::ACT_ALLOCATE) ? '0
                                                              : req_slot_ext[IDX_W-1:0];
        end
      end
      rcsp_pkg::ST_SCAN: begin
        // step to the next slot, carrying its frame offset along
        if (busy_bit && (idx != IDX_W'(SLOTS - 1))) begin
          idx <= idx + IDX_W'(1);
          acc <= alu_sum;
        end
      end
      rcsp_pkg::ST_MUL: begin
        acc  <= alu_sum;
        bitk <= bitk - rcsp_pkg::SLOT_BIT_W'(1);
      end
      rcsp_pkg::ST_ADDR: begin
        payload <= alu_sum;
      end
      rcsp_pkg::ST_FINISH: begin
        rsp_q <= rsp_next;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/refcounted_slot_pool_unit.sv */
// ----------------------------------------------------------------------------
// refcounted_slot_pool_unit
// Pool of message slots with pending-read counts: allocate, release, locate.
// ----------------------------------------------------------------------------
// release and locate: 3-step shift-add of slot times stride, one header add, then
// the commit step; the result strobe is registered after the commit step
// allocate: scan one slot per cycle from 0, header add if one is free, commit step
// busy stays high until the result cycle; a new start is taken in that cycle
// the receiver cannot stall: done is high for exactly one cycle, rsp holds until the next result
// reset: every slot free, subscriber_count 0, message_length 64
module refcounted_slot_pool_unit #(
  parameter int SLOTS        = rcsp_pkg::SLOTS_DEF,
  parameter int HEADER_BYTES = rcsp_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  rcsp_pkg::req_t                 req,
  output logic                           done,
  output rcsp_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcsp_pkg::MSG_W-1:0]     cfg_data
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTF_W = $clog2(SLOTS + 1);

  logic [rcsp_pkg::SUB_W-1:0]  sub_count;
  logic [rcsp_pkg::ADDR_W-1:0] stride;

  logic                        rd_en;
  logic [IDX_W-1:0]            rd_idx;
  logic [rcsp_pkg::CNT_W-1:0]  rd_data;
  logic [IDX_W-1:0]            idx;
  logic                        busy_bit;
  rcsp_pkg::store_cmd_t        cmd;
  logic [CNTF_W-1:0]           free_next;
  logic                        alu_dbl;
  logic [rcsp_pkg::ADDR_W-1:0] alu_a;
  logic [rcsp_pkg::ADDR_W-1:0] alu_b;
  logic [rcsp_pkg::ADDR_W-1:0] alu_sum;

  assign cfg_ready = 1'b1;

  // the slot stride is kept ready instead of the raw message length
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_count <= '0;
      stride    <= rcsp_pkg::ADDR_W'(HEADER_BYTES + rcsp_pkg::MSG_LEN_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcsp_pkg::CFG_SUBSCRIBERS: sub_count <= cfg_data[rcsp_pkg::SUB_W-1:0];
        rcsp_pkg::CFG_MSG_LENGTH: begin
          stride <= rcsp_pkg::ADDR_W'(HEADER_BYTES) + rcsp_pkg::ADDR_W'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  rcsp_ctrl #(
    .SLOTS        (SLOTS),
    .HEADER_BYTES (HEADER_BYTES),
    .IDX_W        (IDX_W),
    .CNTF_W       (CNTF_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .sub_count (sub_count),
    .stride    (stride),
    .done      (done),
    .rsp       (rsp),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .idx_out   (idx),
    .busy_bit  (busy_bit),
    .cmd       (cmd),
    .free_next (free_next),
    .alu_dbl   (alu_dbl),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_sum   (alu_sum)
  );

  rcsp_store #(
    .SLOTS  (SLOTS),
    .IDX_W  (IDX_W),
    .CNTF_W (CNTF_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .idx       (idx),
    .busy_bit  (busy_bit),
    .cmd       (cmd),
    .free_next (free_next)
  );

  rcsp_alu u_alu (
    .dbl (alu_dbl),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

endmodule

/* test/rcsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_checker
// Follows every request, result and register transfer of the slot pool,
// keeps its own copy of the slot counts and register values, and compares
// each result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rcsp_checker #(
  parameter int SLOTS        = rcsp_pkg::SLOTS_DEF,
  parameter int HEADER_BYTES = rcsp_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  rcsp_pkg::req_t                 req,
  input  logic                           done,
  input  rcsp_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rcsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcsp_pkg::MSG_W-1:0]     cfg_data,
  output int                             outstanding,
  output int                             fail_count,
  output int                             results_seen
);

  logic [rcsp_pkg::CNT_W-1:0] reads_left [SLOTS];
  logic [rcsp_pkg::SUB_W-1:0] readers;
  logic [rcsp_pkg::MSG_W-1:0] msg_len;
  rcsp_pkg::rsp_t             expected_q [$];
  rcsp_pkg::rsp_t             want;
  int                         bad = 0;
  int                         checked = 0;

  assign fail_count   = bad;
  assign results_seen = checked;

  function automatic logic [rcsp_pkg::FREE_W-1:0] free_total();
    logic [rcsp_pkg::FREE_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (reads_left[i] == '0) n++;
    end
    return n;
  endfunction

  function automatic logic [rcsp_pkg::ADDR_W-1:0] frame_offset(input int idx);
    int stride;
    stride = HEADER_BYTES + int'(msg_len);
    return rcsp_pkg::ADDR_W'(idx * stride);
  endfunction

  // applies one request to the local slot counts and returns its result
  function automatic rcsp_pkg::rsp_t apply_request(input rcsp_pkg::req_t r);
    rcsp_pkg::rsp_t o;
    int             idx;
    logic           found;
    o     = '0;
    found = 1'b0;
    idx   = int'(r.slot);
    if (r.action == rcsp_pkg::ACT_ALLOCATE) begin
      o.status = rcsp_pkg::STAT_NO_FREE;
      for (int i = 0; i < SLOTS && !found; i++) begin
        if (reads_left[i] == '0) begin
          found           = 1'b1;
          reads_left[i]   = rcsp_pkg::CNT_W'({1'b0, readers})
                            + rcsp_pkg::CNT_W'(r.for_transmit);
          o.status        = rcsp_pkg::STAT_OK;
          o.slot_index    = rcsp_pkg::SLOT_W'(i);
          o.frame_address = frame_offset(i);
          o.payload_address = frame_offset(i) + rcsp_pkg::ADDR_W'(HEADER_BYTES);
          o.pending_reads = reads_left[i];
        end
      end
    end else begin
      o.status          = rcsp_pkg::STAT_OK;
      o.slot_index      = r.slot;
      o.frame_address   = frame_offset(idx);
      o.payload_address = frame_offset(idx) + rcsp_pkg::ADDR_W'(HEADER_BYTES);
      if (r.action == rcsp_pkg::ACT_RELEASE) begin
        if (idx >= SLOTS || reads_left[idx] == '0) begin
          o.status = rcsp_pkg::STAT_ALREADY_FREE;
        end else begin
          reads_left[idx] = reads_left[idx] - 1'b1;
          o.pending_reads = reads_left[idx];
        end
      end else if (idx < SLOTS) begin
        // locate, and the spare action code behaves as locate
        o.pending_reads = reads_left[idx];
      end
    end
    o.free_slots = free_total();
    return o;
  endfunction

  task automatic compare_field(input string field,
                               input logic [rcsp_pkg::ADDR_W-1:0] want_v,
                               input logic [rcsp_pkg::ADDR_W-1:0] got_v);
    if (got_v !== want_v) begin
      bad++;
      if (bad <= 10) begin
        $display("rcsp_checker: result %0d %s expected %0d got %0d",
                 checked, field, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) reads_left[i] = '0;
      readers = '0;
      msg_len = rcsp_pkg::MSG_W'(rcsp_pkg::MSG_LEN_RESET);
      expected_q.delete();
    end else begin
      // result transfer is compared before a request taken at the same edge
      if (done) begin
        if (expected_q.size() == 0) begin
          bad++;
          if (bad <= 10) $display("rcsp_checker: result with nothing outstanding: %p", rsp);
        end else begin
          want = expected_q.pop_front();
          compare_field("status", rcsp_pkg::ADDR_W'(want.status),
                        rcsp_pkg::ADDR_W'(rsp.status));
          compare_field("slot_index", rcsp_pkg::ADDR_W'(want.slot_index),
                        rcsp_pkg::ADDR_W'(rsp.slot_index));
          compare_field("frame_address", want.frame_address, rsp.frame_address);
          compare_field("payload_address", want.payload_address, rsp.payload_address);
          compare_field("pending_reads", rcsp_pkg::ADDR_W'(want.pending_reads),
                        rcsp_pkg::ADDR_W'(rsp.pending_reads));
          compare_field("free_slots", rcsp_pkg::ADDR_W'(want.free_slots),
                        rcsp_pkg::ADDR_W'(rsp.free_slots));
          checked++;
        end
      end
      if (start && !busy) expected_q.push_back(apply_request(req));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rcsp_pkg::CFG_SUBSCRIBERS) begin
          readers = cfg_data[rcsp_pkg::SUB_W-1:0];
        end else if (cfg_index == rcsp_pkg::CFG_MSG_LENGTH) begin
          msg_len = cfg_data;
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the slot pool with directed corner requests and long random runs
// under several subscriber counts, message lengths and sender gap rates;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 248;
  localparam int DRAIN_EVERY     = 100;
  localparam int TAIL_CYCLES     = 20;

  // spare action code, handled as locate
  localparam logic [rcsp_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  rcsp_pkg::req_t                 req;
  logic                           done;
  rcsp_pkg::rsp_t                 rsp;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rcsp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rcsp_pkg::MSG_W-1:0]     cfg_data;

  int outstanding;
  int fail_count;
  int results_seen;
  int requests_sent = 0;
  int settings_written = 0;
  int quiet_cycles = 0;

  logic [rcsp_pkg::SUB_W-1:0] phase_readers [PHASES] =
    '{4'd1, 4'd15, 4'd0, 4'd3, 4'd15, 4'd2};
  logic [rcsp_pkg::MSG_W-1:0] phase_len [PHASES] =
    '{11'd64, 11'd1024, 11'd1, 11'd2047, 11'd0, 11'd300};
  int                         phase_idle [PHASES] = '{0, 55, 6, 0, 55, 6};

  refcounted_slot_pool_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcsp_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .done         (done),
    .rsp          (rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: no transfer for %0d cycles", quiet_cycles);
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic rcsp_pkg::req_t make_req(input logic [rcsp_pkg::ACTION_W-1:0] action,
                                              input logic [rcsp_pkg::SLOT_W-1:0] slot,
                                              input logic tx);
    rcsp_pkg::req_t r;
    r.action       = action;
    r.slot         = slot;
    r.for_transmit = tx;
    return r;
  endfunction

  function automatic rcsp_pkg::req_t random_request();
    rcsp_pkg::req_t r;
    int             pick;
    pick           = $urandom_range(0, 99);
    r.for_transmit = 1'($urandom_range(0, 1));
    // low slots are the ones allocation fills first
    if ($urandom_range(0, 1) == 1) begin
      r.slot = rcsp_pkg::SLOT_W'($urandom_range(0, 3));
    end else begin
      r.slot = rcsp_pkg::SLOT_W'($urandom_range(0, rcsp_pkg::SLOTS_DEF - 1));
    end
    if (pick < 35) r.action = rcsp_pkg::ACT_ALLOCATE;
    else if (pick < 85) r.action = rcsp_pkg::ACT_RELEASE;
    else if (pick < 95) r.action = rcsp_pkg::ACT_LOCATE;
    else r.action = ACT_SPARE;
    return r;
  endfunction

  task automatic send(input rcsp_pkg::req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  task automatic sender_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_pool_config(input logic [rcsp_pkg::SUB_W-1:0] readers,
                                   input logic [rcsp_pkg::MSG_W-1:0] len);
    logic [rcsp_pkg::MSG_W-rcsp_pkg::SUB_W-1:0] spare;
    spare = (rcsp_pkg::MSG_W - rcsp_pkg::SUB_W)'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= rcsp_pkg::CFG_SUBSCRIBERS;
    cfg_data  <= {spare, readers};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= rcsp_pkg::CFG_MSG_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= rcsp_pkg::CFG_SUBSCRIBERS;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no readers, so a slot allocated without transmit stays free
    send(make_req(rcsp_pkg::ACT_ALLOCATE, 3'd5, 1'b0));
    send(make_req(rcsp_pkg::ACT_RELEASE, 3'd0, 1'b0));
    repeat (rcsp_pkg::SLOTS_DEF) send(make_req(rcsp_pkg::ACT_ALLOCATE, 3'd7, 1'b1));
    send(make_req(rcsp_pkg::ACT_ALLOCATE, 3'd0, 1'b1));
    send(make_req(rcsp_pkg::ACT_RELEASE, 3'd7, 1'b0));
    send(make_req(rcsp_pkg::ACT_RELEASE, 3'd7, 1'b1));
    send(make_req(rcsp_pkg::ACT_LOCATE, 3'd7, 1'b1));
    send(make_req(ACT_SPARE, 3'd2, 1'b0));
    drain();

    // largest count and the longest regular message
    write_pool_config(4'd15, 11'd1024);
    send(make_req(rcsp_pkg::ACT_ALLOCATE, 3'd0, 1'b1));
    send(make_req(rcsp_pkg::ACT_LOCATE, 3'd7, 1'b0));
    send(make_req(rcsp_pkg::ACT_RELEASE, 3'd7, 1'b1));
    send(make_req(rcsp_pkg::ACT_ALLOCATE, 3'd3, 1'b0));
    drain();

    // out-of-range length, addresses near the top of the field
    write_pool_config(4'd0, 11'd2047);
    send(make_req(rcsp_pkg::ACT_LOCATE, 3'd7, 1'b0));
    send(make_req(ACT_SPARE, 3'd0, 1'b1));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_pool_config(phase_readers[p], phase_len[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        sender_gap(phase_idle[p]);
        send(random_request());
        if (k % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d requests over %0d register settings, %0d results compared",
             requests_sent, settings_written, results_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rcsp_pkg.sv
hw/rtl/rcsp_alu.sv
hw/rtl/rcsp_store.sv
hw/rtl/rcsp_ctrl.sv
hw/rtl/refcounted_slot_pool_unit.sv
test/rcsp_checker.sv
test/tb.sv
